/* rtl/cte_pkg.sv */
// Shared types and codes of the capability table engine.
package cte_pkg;
    localparam int SlotW = 8;
    localparam int DomW  = 8;
    localparam int RgtW  = 16;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0, CMD_CHECK = 3'd1, CMD_XFER = 3'd2,
        CMD_DERIVE = 3'd3, CMD_REVOKE = 3'd4, CMD_INFO = 3'd5
    } t_cmd;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PARAM   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_REVOKED = 3'd4;
    localparam logic [2:0] ST_PERM    = 3'd5;

    localparam logic [1:0] KIND_MEM  = 2'd0;
    localparam logic [1:0] KIND_MMIO = 2'd1;
    localparam logic [1:0] KIND_IRQ  = 2'd2;
    localparam logic [1:0] KIND_DER  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  domain;
        logic [7:0]  other_domain;
        logic [7:0]  cap_slot;
        logic [15:0] rights;
        logic [1:0]  cap_kind;
        logic [63:0] base_address;
        logic [63:0] region_length;
        logic [7:0]  irq_line;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_out;
        logic [1:0]  kind_out;
        logic [7:0]  owner_out;
        logic [15:0] rights_out;
        logic [15:0] refs_out;
        logic        revoked_out;
        logic [63:0] base_out;
        logic [63:0] length_out;
        logic [7:0]  line_out;
        logic [7:0]  parent_out;
    } t_rsp;

    // One stored table entry (valid bits live in flops).
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rights;
        logic [7:0]  owner;
        logic [15:0] refs;
        logic        revoked;
        logic [63:0] base;
        logic [63:0] length;
        logic [7:0]  line;
        logic [7:0]  parent;
    } t_entry;

    localparam int EntW = $bits(t_entry);
endpackage

/* rtl/cte_if.sv */
// Valid/ready channel interfaces for requests, responses and configuration.
interface cte_req_if;
    import cte_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cte_rsp_if;
    import cte_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cte_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cte_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/capability_table_engine_core.sv */
// Capability table engine: entry RAM plus valid-bit free-slot search.
// Each accepted item is read from the RAM, then decided and written back in S_EXEC; a
// successful derive also passes through S_BUMP, which writes the parent's advanced refs.
// Input is held off until the result is taken, so no new item enters while one is in
// flight. Entries never written read as zero through per-slot written flags;
// synchronous reset clears flags, device rights 7.
module capability_table_engine_core #(
    parameter int SLOTS       = 256,
    parameter int DOMAINS     = 16,
    parameter int RIGHTS_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cte_req_if.sink     req,
    cte_rsp_if.source   rsp,
    cte_cfg_if.sink     cfg
);
    import cte_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam logic [15:0] RMASK = (RIGHTS_BITS >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << RIGHTS_BITS) - 32'd1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_BUMP, S_OUT} t_state;

    t_state           r_state;
    t_req             r_req;
    logic [15:0]      r_dev;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_wr;   // entry ever written
    t_rsp             r_rsp;
    logic [AW-1:0]    r_bslot;
    t_entry           r_bent;

    logic             we;
    logic [AW-1:0]    waddr;
    t_entry           wdata;
    t_entry           rdata;
    t_entry           ent;
    t_entry           bent;
    logic [AW-1:0]    free_idx;
    logic             free_ok;

    // Take items only when idle; cfg only when idle too.
    assign req.ready = (r_state == S_IDLE);
    assign cfg.ready = (r_state == S_IDLE);
    assign rsp.valid = (r_state == S_OUT);
    assign rsp.data  = r_rsp;

    cte_ram #(.WIDTH(EntW), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(req.data.cap_slot[AW-1:0]),
        .o_rdata(rdata)
    );

    // Lowest free slot from 1 up.
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 1; i--) begin
            if (!r_valid[i]) begin
                free_idx = AW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    // Decide command, form write-back and response.
    logic [AW-1:0] sl;
    logic          sl_ok, dom_ok, odom_ok, vld;
    logic [15:0]   rr;
    t_rsp          n_rsp;
    logic [1:0]    n_set;  // 1 mark slot valid at waddr
    always_comb begin
        sl      = r_req.cap_slot[AW-1:0];
        sl_ok   = {24'd0, r_req.cap_slot} < 32'(SLOTS);
        dom_ok  = {24'd0, r_req.domain} < 32'(DOMAINS);
        odom_ok = {24'd0, r_req.other_domain} < 32'(DOMAINS);
        vld     = r_valid[sl];
        rr      = r_req.rights & RMASK;
        ent     = r_wr[sl] ? rdata : '0;
        bent    = ent;
        if (ent.refs != 16'hFFFF) bent.refs = ent.refs + 16'd1;
        n_rsp   = '0;
        we      = 1'b0;
        waddr   = sl;
        wdata   = ent;
        n_set   = 2'd0;
        case (r_req.command)
            CMD_CREATE: begin
                if (!dom_ok || r_req.cap_kind > KIND_IRQ) n_rsp.status = ST_PARAM;
                else if (!free_ok) n_rsp.status = ST_FULL;
                else begin
                    we = 1'b1; waddr = free_idx; n_set = 2'd1;
                    wdata = '0;
                    wdata.kind  = r_req.cap_kind;
                    wdata.owner = r_req.domain;
                    wdata.refs  = 16'd1;
                    if (r_req.cap_kind == KIND_IRQ) wdata.line = r_req.irq_line;
                    else begin
                        wdata.rights = (r_req.cap_kind == KIND_MMIO) ? (r_dev & RMASK) : rr;
                        wdata.base   = r_req.base_address;
                        wdata.length = r_req.region_length;
                    end
                    n_rsp.slot_out = 8'(free_idx);
                end
            end
            CMD_CHECK: begin
                if (!dom_ok || !sl_ok) n_rsp.status = ST_PARAM;
                else if (!vld) n_rsp.status = ST_INVALID;
                else if (ent.revoked) n_rsp.status = ST_REVOKED;
                else if (ent.owner != r_req.domain) n_rsp.status = ST_PERM;
                else if ((ent.rights & rr) != rr) n_rsp.status = ST_PERM;
            end
            CMD_XFER: begin
                if (!dom_ok || !odom_ok || !sl_ok) n_rsp.status = ST_PARAM;
                else if (ent.owner != r_req.domain) n_rsp.status = ST_PERM;
                else begin
                    we = 1'b1;
                    wdata.owner = r_req.other_domain;
                    wdata.refs  = bent.refs;
                end
            end
            CMD_DERIVE: begin
                if (!dom_ok || !sl_ok) n_rsp.status = ST_PARAM;
                else if (!vld || ent.owner != r_req.domain) n_rsp.status = ST_INVALID;
                else if ((rr & ent.rights) != rr) n_rsp.status = ST_PARAM;
                else if (!free_ok) n_rsp.status = ST_FULL;
                else begin
                    // New entry now; parent refs bump in the next cycle.
                    we = 1'b1; waddr = free_idx; n_set = 2'd1;
                    wdata = '0;
                    wdata.kind   = KIND_DER;
                    wdata.rights = rr;
                    wdata.owner  = r_req.domain;
                    wdata.refs   = 16'd1;
                    wdata.parent = r_req.cap_slot;
                    n_rsp.slot_out = 8'(free_idx);
                end
            end
            CMD_REVOKE: begin
                if (!sl_ok) n_rsp.status = ST_PARAM;
                else if (ent.revoked) n_rsp.status = ST_REVOKED;
                else begin
                    we = 1'b1; wdata.revoked = 1'b1; wdata.refs = 16'd0;
                end
            end
            CMD_INFO: begin
                if (!sl_ok) n_rsp.status = ST_PARAM;
                else if (!vld) n_rsp.status = ST_INVALID;
                else begin
                    n_rsp.kind_out    = ent.kind;
                    n_rsp.owner_out   = ent.owner;
                    n_rsp.rights_out  = ent.rights;
                    n_rsp.refs_out    = ent.refs;
                    n_rsp.revoked_out = ent.revoked;
                    n_rsp.base_out    = ent.base;
                    n_rsp.length_out  = ent.length;
                    n_rsp.line_out    = ent.line;
                    n_rsp.parent_out  = ent.parent;
                end
            end
            default: n_rsp.status = ST_PARAM;
        endcase
        // Write the parent with its refs advanced, in the cycle after the child write.
        if (r_state == S_BUMP) begin
            we = 1'b1; waddr = r_bslot; wdata = r_bent; n_set = 2'd0;
        end else if (r_state != S_EXEC) begin
            we = 1'b0; n_set = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dev   <= 16'd7;
            r_valid <= '0;
            r_wr    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cfg.valid) r_dev <= cfg.data;
                    if (req.valid) begin
                        r_req   <= req.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rsp   <= n_rsp;
                    if (we) r_wr[waddr] <= 1'b1;
                    if (n_set == 2'd1) r_valid[waddr] <= 1'b1;
                    if (r_req.command == CMD_DERIVE && n_rsp.slot_out != 8'd0) begin
                        r_bslot <= sl;
                        r_bent  <= bent;
                        r_state <= S_BUMP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_BUMP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/cte_checker.sv */
// Port-level checker for the capability table engine, bound to the engine core.
module cte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [7:0]  rsp_slot
);
    // No new item while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("ready while result pending");
    // Accepted item yields a result once executed and, for a derive, its parent written.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && req_ready) |=> ##[1:2] rsp_valid) else $error("late result");
    // Allocated slot only on ok.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_slot != 8'd0) |-> rsp_status == 3'd0)
        else $error("slot on failure");
    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
        else $error("result dropped");
endmodule

bind capability_table_engine_core cte_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.data.status), .rsp_slot(rsp.data.slot_out)
);

/* tb/sv/tb_capability_table_engine_core.sv */
// Self-checking testbench for the capability table engine core.
module tb_capability_table_engine_core;
    import cte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = 256;
    localparam int NDOM       = 16;
    localparam int IDLE_WAIT  = 8;
    localparam int WDOG_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    logic i_clk;
    logic i_rst_n;

    cte_req_if req_ch ();
    cte_rsp_if rsp_ch ();
    cte_cfg_if cfg_ch ();

    capability_table_engine_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req_ch.sink),
        .rsp    (rsp_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Shadow copy of the capability table
    logic        tbl_valid   [NSLOT];
    logic [1:0]  tbl_kind    [NSLOT];
    logic [15:0] tbl_rights  [NSLOT];
    logic [7:0]  tbl_owner   [NSLOT];
    logic [15:0] tbl_refs    [NSLOT];
    logic        tbl_revoked [NSLOT];
    logic [63:0] tbl_base    [NSLOT];
    logic [63:0] tbl_length  [NSLOT];
    logic [7:0]  tbl_line    [NSLOT];
    logic [7:0]  tbl_parent  [NSLOT];
    logic [15:0] mmio_rights;
    int          top_slot;

    t_req pending_cmds [$];
    t_rsp expected_rsps[$];

    int  mismatch_cnt;
    bit  failed;
    bit  req_taken;
    int  gap_left;
    bit  no_idle;
    int  hold_left;
    int  long_hold_asks;
    int  long_hold_done;
    int  quiet_cycles;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Fill a fresh entry
    function automatic void fill_entry(int s, logic [1:0] k, logic [15:0] r, logic [7:0] own);
        tbl_valid[s]   = 1'b1;
        tbl_kind[s]    = k;
        tbl_rights[s]  = r;
        tbl_owner[s]   = own;
        tbl_refs[s]    = 16'd1;
        tbl_revoked[s] = 1'b0;
        tbl_base[s]    = '0;
        tbl_length[s]  = '0;
        tbl_line[s]    = '0;
        tbl_parent[s]  = '0;
        if (s > top_slot) top_slot = s;
    endfunction

    function automatic int lowest_free();
        for (int i = 1; i < NSLOT; i++)
            if (!tbl_valid[i]) return i;
        return 0;
    endfunction

    function automatic void count_up(int s);
        if (tbl_refs[s] != 16'hFFFF) tbl_refs[s] = tbl_refs[s] + 16'd1;
    endfunction

    // Apply one command to the shadow table and form its response
    function automatic t_rsp apply_command(t_req q);
        t_rsp o;
        int   s;
        int   p;
        o = '0;
        p = q.cap_slot;
        case (q.command)
            CMD_CREATE: begin
                if (q.domain >= NDOM || q.cap_kind == KIND_RSVD) begin
                    o.status = ST_PARAM;
                end else begin
                    s = lowest_free();
                    if (s == 0) begin
                        o.status = ST_FULL;
                    end else begin
                        if (q.cap_kind == KIND_MEM) begin
                            fill_entry(s, KIND_MEM, q.rights, q.domain);
                            tbl_base[s]   = q.base_address;
                            tbl_length[s] = q.region_length;
                        end else if (q.cap_kind == KIND_MMIO) begin
                            fill_entry(s, KIND_MMIO, mmio_rights, q.domain);
                            tbl_base[s]   = q.base_address;
                            tbl_length[s] = q.region_length;
                        end else begin
                            fill_entry(s, KIND_IRQ, 16'd0, q.domain);
                            tbl_line[s] = q.irq_line;
                        end
                        o.status   = ST_OK;
                        o.slot_out = s[7:0];
                    end
                end
            end
            CMD_CHECK: begin
                if (q.domain >= NDOM) o.status = ST_PARAM;
                else if (!tbl_valid[p]) o.status = ST_INVALID;
                else if (tbl_revoked[p]) o.status = ST_REVOKED;
                else if (tbl_owner[p] != q.domain) o.status = ST_PERM;
                else if ((tbl_rights[p] & q.rights) != q.rights) o.status = ST_PERM;
                else o.status = ST_OK;
            end
            CMD_XFER: begin
                if (q.domain >= NDOM || q.other_domain >= NDOM) begin
                    o.status = ST_PARAM;
                end else if (tbl_owner[p] != q.domain) begin
                    o.status = ST_PERM;
                end else begin
                    tbl_owner[p] = q.other_domain;
                    count_up(p);
                    o.status = ST_OK;
                end
            end
            CMD_DERIVE: begin
                if (q.domain >= NDOM) begin
                    o.status = ST_PARAM;
                end else if (!tbl_valid[p] || tbl_owner[p] != q.domain) begin
                    o.status = ST_INVALID;
                end else if ((q.rights & tbl_rights[p]) != q.rights) begin
                    o.status = ST_PARAM;
                end else begin
                    s = lowest_free();
                    if (s == 0) begin
                        o.status = ST_FULL;
                    end else begin
                        fill_entry(s, KIND_DER, q.rights, q.domain);
                        tbl_parent[s] = q.cap_slot;
                        count_up(p);
                        o.status   = ST_OK;
                        o.slot_out = s[7:0];
                    end
                end
            end
            CMD_REVOKE: begin
                if (tbl_revoked[p]) begin
                    o.status = ST_REVOKED;
                end else begin
                    tbl_revoked[p] = 1'b1;
                    tbl_refs[p]    = 16'd0;
                    o.status = ST_OK;
                end
            end
            CMD_INFO: begin
                if (!tbl_valid[p]) begin
                    o.status = ST_INVALID;
                end else begin
                    o.status      = ST_OK;
                    o.kind_out    = tbl_kind[p];
                    o.owner_out   = tbl_owner[p];
                    o.rights_out  = tbl_rights[p];
                    o.refs_out    = tbl_refs[p];
                    o.revoked_out = tbl_revoked[p];
                    o.base_out    = tbl_base[p];
                    o.length_out  = tbl_length[p];
                    o.line_out    = tbl_line[p];
                    o.parent_out  = tbl_parent[p];
                end
            end
            default: o.status = ST_PARAM;
        endcase
        return o;
    endfunction

    function automatic t_req make_cmd(logic [2:0] c, logic [7:0] d, logic [7:0] od,
                                      logic [7:0] sl, logic [15:0] r, logic [1:0] k,
                                      logic [63:0] b, logic [63:0] l, logic [7:0] ln);
        t_req q;
        q.command = c; q.domain = d; q.other_domain = od; q.cap_slot = sl;
        q.rights = r; q.cap_kind = k; q.base_address = b; q.region_length = l;
        q.irq_line = ln;
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] pick_domain();
        int w;
        w = $urandom_range(0, 99);
        if (w < 92) return $urandom_range(0, NDOM - 1);
        return $urandom_range(NDOM, 255);
    endfunction

    function automatic logic [7:0] pick_slot();
        int w;
        w = $urandom_range(0, 99);
        if (w < 85) return $urandom_range(1, (top_slot + 2 > 255) ? 255 : top_slot + 2);
        if (w < 90) return 8'd0;
        return $urandom_range(0, 255);
    endfunction

    // Random command, mostly aimed at live entries and their owners
    function automatic t_req random_cmd();
        t_req q;
        int   w;
        int   p;
        q = make_cmd(3'd0, pick_domain(), pick_domain(), pick_slot(), $urandom(),
                     $urandom_range(0, 2), rand64(), rand64(), $urandom());
        w = $urandom_range(0, 99);
        if (w < 30) q.command = CMD_CREATE;
        else if (w < 48) q.command = CMD_CHECK;
        else if (w < 58) q.command = CMD_XFER;
        else if (w < 72) q.command = CMD_DERIVE;
        else if (w < 80) q.command = CMD_REVOKE;
        else if (w < 97) q.command = CMD_INFO;
        else q.command = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
        if (q.command == CMD_CREATE && $urandom_range(0, 29) == 0) q.cap_kind = KIND_RSVD;
        p = q.cap_slot;
        if ($urandom_range(0, 99) < 70 && tbl_owner[p] < NDOM) q.domain = tbl_owner[p];
        if ($urandom_range(0, 99) < 70) q.rights = tbl_rights[p] & $urandom();
        return q;
    endfunction

    function automatic int pick_gap();
        int w;
        if (no_idle) return 0;
        w = $urandom_range(0, 99);
        if (w < 60) return 0;
        if (w < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Request driver: hold an offered item until taken, then advance
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            req_ch.valid <= 1'b1;
        end else if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
            req_ch.data  <= pending_cmds.pop_front();
            req_ch.valid <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Response receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_asks != long_hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_done <= long_hold_done + 1;
        end else if (no_idle || $urandom_range(0, 99) < 70) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= 1'b0;
            hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    function automatic void check_field(string nm, logic [63:0] ex, logic [63:0] ac);
        if (ex !== ac) begin
            failed = 1'b1;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch %s: expected %h actual %h", nm, ex, ac);
        end
    endfunction

    // Monitor: compare responses, then predict newly taken items
    always @(posedge i_clk) begin
        t_rsp ex;
        t_rsp ac;
        req_taken <= req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready
                || cfg_ch.valid && cfg_ch.ready)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready) begin
                ac = rsp_ch.data;
                if (expected_rsps.size() == 0) begin
                    failed = 1'b1;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected response %h", ac);
                end else begin
                    ex = expected_rsps.pop_front();
                    check_field("status", ex.status, ac.status);
                    check_field("slot_out", ex.slot_out, ac.slot_out);
                    check_field("kind_out", ex.kind_out, ac.kind_out);
                    check_field("owner_out", ex.owner_out, ac.owner_out);
                    check_field("rights_out", ex.rights_out, ac.rights_out);
                    check_field("refs_out", ex.refs_out, ac.refs_out);
                    check_field("revoked_out", ex.revoked_out, ac.revoked_out);
                    check_field("base_out", ex.base_out, ac.base_out);
                    check_field("length_out", ex.length_out, ac.length_out);
                    check_field("line_out", ex.line_out, ac.line_out);
                    check_field("parent_out", ex.parent_out, ac.parent_out);
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(apply_command(req_ch.data));
            if (cfg_ch.valid && cfg_ch.ready)
                mmio_rights = cfg_ch.data;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_device_rights(logic [15:0] v);
        @(negedge i_clk);
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 0; tbl_kind[i] = 0; tbl_rights[i] = 0; tbl_owner[i] = 0;
            tbl_refs[i] = 0; tbl_revoked[i] = 0; tbl_base[i] = 0; tbl_length[i] = 0;
            tbl_line[i] = 0; tbl_parent[i] = 0;
        end
        mmio_rights = 16'd7;
        top_slot = 0;
        mismatch_cnt = 0;
        failed = 0;
        gap_left = 0;
        no_idle = 0;
        hold_left = 0;
        long_hold_asks = 0;
        long_hold_done = 0;
        quiet_cycles = 0;
        req_taken = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        rsp_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        repeat (IDLE_WAIT) @(negedge i_clk);

        // Directed: extremes, every command and the corner cases
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd3, 8'd0, 8'd0, 16'hFFFF, KIND_MEM,
                                        '1, '1, 8'hFF));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd15, 8'hFF, 8'hFF, 16'h0000, KIND_MMIO,
                                        '0, '0, 8'h00));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd0, 8'd0, 8'd0, 16'hFFFF, KIND_IRQ,
                                        '1, '1, 8'hFF));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd1, 8'd0, 8'd0, 16'h1, KIND_RSVD,
                                        '0, '0, 8'd0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd16, 8'd0, 8'd0, 16'h1, KIND_MEM,
                                        '0, '0, 8'd0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'd3, 8'd0, 8'd1, 16'h00F0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'd4, 8'd0, 8'd1, 16'h0001, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'd15, 8'd0, 8'd2, 16'h0008, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'd3, 8'd0, 8'd0, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'hFF, 8'd0, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_XFER, 8'd0, 8'd9, 8'd200, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_XFER, 8'd3, 8'd16, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_XFER, 8'd5, 8'd6, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_XFER, 8'd3, 8'd7, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DERIVE, 8'd7, 8'd0, 8'd1, 16'h00FF, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DERIVE, 8'd15, 8'd0, 8'd2, 16'h0008, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DERIVE, 8'd15, 8'd0, 8'd100, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REVOKE, 8'd0, 8'd0, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REVOKE, 8'd0, 8'd0, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CHECK, 8'd7, 8'd0, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DERIVE, 8'd7, 8'd0, 8'd1, 16'h0F00, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REVOKE, 8'd0, 8'd0, 8'd6, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 8'd2, 8'd0, 8'd0, 16'h5A5A, KIND_MEM,
                                        '1, '0, 8'd0));
        pending_cmds.push_back(make_cmd(CMD_INFO, 8'd0, 8'd0, 8'd6, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INFO, 8'd0, 8'd0, 8'd255, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RSVD6, 8'd0, 8'd0, 8'd1, 16'h0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RSVD7, 8'hFF, 8'hFF, 8'hFF, '1, 2'd3,
                                        '1, '1, 8'hFF));
        drain();

        // Random phases across several MMIO rights settings
        write_device_rights(16'hFFFF);
        no_idle = 1;
        queue_random(150);
        drain();
        no_idle = 0;

        write_device_rights(16'h0000);
        queue_random(180);
        while (pending_cmds.size() > 120) @(negedge i_clk);
        long_hold_asks = 1;
        drain();

        write_device_rights($urandom());
        queue_random(180);
        drain();

        write_device_rights(16'h8001);
        queue_random(190);
        drain();

        if (!failed && expected_rsps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
